// ===== rtl/b64e_pkg.sv =====
// Package for the base64 stream encoder.
// Holds the group record passed from front to back and the alphabet lookup.
// No dependencies.
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] PLUS_CHAR  = 7'h2B;
    localparam logic [6:0] SLASH_CHAR = 7'h2F;
    localparam logic [6:0] UPPER_A    = 7'h41;
    localparam logic [6:0] LOWER_A    = 7'h61;
    localparam logic [6:0] DIGIT_0    = 7'h30;
    localparam int         QUEUE_DEPTH = 2;
    localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        logic [1:0] last_data;
        logic       fin;
    } group_t;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] ch;
        priority if (v < 6'd26) begin
            ch = UPPER_A + {1'b0, v};
        end else if (v < 6'd52) begin
            ch = LOWER_A + {1'b0, v} - 7'd26;
        end else if (v < 6'd62) begin
            ch = DIGIT_0 + {1'b0, v} - 7'd52;
        end else if (v == 6'd62) begin
            ch = PLUS_CHAR;
        end else begin
            ch = SLASH_CHAR;
        end
        return ch;
    endfunction

endpackage

// ===== rtl/base64_stream_encoder.sv =====
// Top level of the base64 stream encoder: front, group queue, back.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
//  channel | dir | tdata              | tuser        | tlast
//  s_      | in  | [7:0] data_byte    | -            | final_byte
//  m_      | out | [6:0] out_char     | last_in_run  | end_of_text
//
// A byte is taken every cycle while the group queue has a free slot.
// The back end sends one character per cycle while m_tready is high, so each group
// of three bytes becomes four characters; a closing byte's group passes through the
// queue slot and the back end's group register before its first character is valid on m_.
// Reset clears the held-byte count, the queue and the output valid flag.
// A stall on m_ holds the output register; s_ keeps accepting until the queue fills.
module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tuser,   // [0] last_in_run
    output logic       m_tlast
);
    import b64e_pkg::*;

    logic   push_valid, push_ready;
    group_t push_data;
    logic   pop_valid, pop_ready;
    group_t pop_data;
    logic [6:0] out_char;

    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_fin     (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b64e_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    b64e_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (pop_valid),
        .grp_ready (pop_ready),
        .grp_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tuser),
        .out_eot   (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

// ===== rtl/b64e_front.sv =====
// Front end: accepts raw bytes, holds the open group, issues complete groups and, on the final byte, a partial one.
// Depends on b64e_pkg.
module b64e_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            in_fin,
    output logic            push_valid,
    input  logic            push_ready,
    output b64e_pkg::group_t push_data
);
    import b64e_pkg::*;

    logic [7:0] pend0_reg, pend0_next;
    logic [7:0] pend1_reg, pend1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       need_push;
    logic       accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign push_valid = in_valid && need_push;

    always_comb begin
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        cnt_next   = cnt_reg;
        need_push  = 1'b0;
        push_data  = '0;
        push_data.fin = in_fin;
        unique case (cnt_reg)
            2'd1: begin
                need_push = in_fin;
                push_data.g0 = pend0_reg;
                push_data.g1 = in_byte;
                push_data.last_data = 2'd2;
                if (accept) begin
                    pend1_next = in_byte;
                    cnt_next   = in_fin ? 2'd0 : 2'd2;
                end
            end
            2'd2: begin
                need_push = 1'b1;
                push_data.g0 = pend0_reg;
                push_data.g1 = pend1_reg;
                push_data.g2 = in_byte;
                push_data.last_data = 2'd3;
                if (accept) begin
                    cnt_next = 2'd0;
                end
            end
            default: begin
                need_push = in_fin;
                push_data.g0 = in_byte;
                push_data.last_data = 2'd1;
                if (accept) begin
                    pend0_next = in_byte;
                    cnt_next   = in_fin ? 2'd0 : 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend0_reg <= '0;
            pend1_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
// Short group queue between front and back ends.
// Depends on b64e_pkg.
module b64e_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  b64e_pkg::group_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output b64e_pkg::group_t rd_data
);
    import b64e_pkg::*;

    group_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_wr;
    logic                do_rd;

    assign wr_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr) begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd) begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: expands one group into four characters, one per cycle while out_ready does not stall the output.
// Depends on b64e_pkg.
module b64e_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             grp_valid,
    output logic             grp_ready,
    input  b64e_pkg::group_t grp_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [6:0]       out_char,
    output logic             out_last,
    output logic             out_eot
);
    import b64e_pkg::*;

    group_t     grp_reg, grp_next;
    logic       active_reg, active_next;
    logic [1:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [6:0] ochar_reg, ochar_next;
    logic       olast_reg, olast_next;
    logic       oeot_reg, oeot_next;
    logic       load;
    logic       finish;
    logic [5:0] sext;

    assign load      = !ovalid_reg || out_ready;
    assign finish    = load && active_reg && (idx_reg == 2'd3);
    assign grp_ready = !active_reg || finish;

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;
    assign out_eot   = oeot_reg;

    always_comb begin
        unique case (idx_reg)
            2'd0:    sext = grp_reg.g0[7:2];
            2'd1:    sext = {grp_reg.g0[1:0], grp_reg.g1[7:4]};
            2'd2:    sext = {grp_reg.g1[3:0], grp_reg.g2[7:6]};
            default: sext = grp_reg.g2[5:0];
        endcase
    end

    always_comb begin
        grp_next    = grp_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        oeot_next   = oeot_reg;
        if (load) begin
            ovalid_next = active_reg;
            ochar_next  = (idx_reg <= grp_reg.last_data) ? b64_char(sext) : PAD_CHAR;
            olast_next  = (idx_reg == 2'd3);
            oeot_next   = (idx_reg == 2'd3) && grp_reg.fin;
            if (active_reg) begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (grp_valid && grp_ready) begin
            grp_next    = grp_data;
            active_next = 1'b1;
            idx_next    = 2'd0;
        end else if (finish) begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg   <= grp_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
        oeot_reg  <= oeot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== rtl/b64e_checker.sv =====
// Port-level checks for the base64 stream encoder, bound to the top level.
// Depends on base64_stream_encoder ports only.
module b64e_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    a_eot_on_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("end of text outside run end");

    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == 1'b0))
        else $error("non-ASCII character");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled request changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
